// ===== src/tdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants of the trial division factorizer
// Widths of the item fields, the trial divider geometry and the sequencer
// state type.
// ----------------------------------------------------------------------------
package tdf_pkg;

   localparam int unsigned NUM_W      = 32;
   localparam int unsigned EXP_W      = 5;
   localparam int unsigned CAND_W     = 17;
   localparam int unsigned SQ_W       = 2 * CAND_W;
   localparam int unsigned PART_W     = CAND_W + 1;
   localparam int unsigned DIV_STEPS  = 4;
   localparam int unsigned DIV_CYCLES = NUM_W / DIV_STEPS;
   localparam int unsigned CNT_W      = $clog2(DIV_CYCLES);

   localparam logic [CAND_W-1:0] FIRST_CAND  = CAND_W'(2);
   localparam logic [CAND_W-1:0] SECOND_CAND = CAND_W'(3);
   localparam logic [SQ_W-1:0]   FIRST_SQ    = SQ_W'(4);
   localparam logic [SQ_W-1:0]   SECOND_SQ   = SQ_W'(9);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV,
      ST_EVAL,
      ST_OUT
   } state_type;

endpackage

// ===== src/trial_division_factorizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Splits a 32-bit number into (prime, exponent) items in ascending order and
// marks the last item of each run.
// ----------------------------------------------------------------------------
//  channel | direction | fields                                         | handshake
//  req     | in        | number                                         | req_valid/req_ready
//  rsp     | out       | prime_factor, exponent, no_factors, last_factor| rsp_valid/rsp_ready
//
//  Each candidate passes a bound test, a remainder test on a shared
//  4-bit-per-cycle divider and an evaluation; the candidates are 2, then odd
//  values up to the square root of the shrinking remainder. Inputs 0 and 1
//  give a single item with no_factors set. Each result waits in the output
//  register until taken; req_ready is high only when idle. Reset returns to
//  idle.
// ----------------------------------------------------------------------------
module trial_division_factorizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tdf_pkg::NUM_W-1:0]     req_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tdf_pkg::NUM_W-1:0]     rsp_prime_factor,
   output logic [tdf_pkg::EXP_W-1:0]     rsp_exponent,
   output logic                          rsp_no_factors,
   output logic                          rsp_last_factor
);

   tdf_pkg::state_type                state_ff, state_in;
   logic [tdf_pkg::NUM_W-1:0]         rem_ff, rem_in;
   logic [tdf_pkg::NUM_W-1:0]         quo_ff, quo_in;
   logic [tdf_pkg::PART_W-1:0]        part_ff, part_in;
   logic [tdf_pkg::CAND_W-1:0]        cand_ff, cand_in;
   logic [tdf_pkg::SQ_W-1:0]          sq_ff, sq_in;
   logic [tdf_pkg::EXP_W-1:0]         exp_ff, exp_in;
   logic [tdf_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [tdf_pkg::NUM_W-1:0]         prime_ff, prime_in;
   logic [tdf_pkg::EXP_W-1:0]         oexp_ff, oexp_in;
   logic                              none_ff, none_in;
   logic                              last_ff, last_in;

   logic [tdf_pkg::PART_W-1:0]        part_step;
   logic [tdf_pkg::NUM_W-1:0]         quo_step;
   logic [tdf_pkg::CAND_W-1:0]        cand_adv;
   logic [tdf_pkg::SQ_W-1:0]          sq_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      part_ff  <= part_in;
      cand_ff  <= cand_in;
      sq_ff    <= sq_in;
      exp_ff   <= exp_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
      oexp_ff  <= oexp_in;
      none_ff  <= none_in;
      last_ff  <= last_in;
   end

   // restoring divide, several quotient bits per cycle
   always_comb begin
      part_step = part_ff;
      quo_step  = quo_ff;
      for (int i = 0; i < int'(tdf_pkg::DIV_STEPS); i++) begin
         part_step = {part_step[tdf_pkg::PART_W-2:0], quo_step[tdf_pkg::NUM_W-1]};
         quo_step  = {quo_step[tdf_pkg::NUM_W-2:0], 1'b0};
         if (part_step >= {1'b0, cand_ff}) begin
            part_step   = part_step - {1'b0, cand_ff};
            quo_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      if (cand_ff == tdf_pkg::FIRST_CAND) begin
         cand_adv = tdf_pkg::SECOND_CAND;
         sq_adv   = tdf_pkg::SECOND_SQ;
      end else begin
         cand_adv = cand_ff + tdf_pkg::CAND_W'(2);
         sq_adv   = sq_ff + {{(tdf_pkg::SQ_W-tdf_pkg::CAND_W-2){1'b0}}, cand_ff, 2'b00}
                    + tdf_pkg::SQ_W'(4);
      end
   end

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      part_in   = part_ff;
      cand_in   = cand_ff;
      sq_in     = sq_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      prime_in  = prime_ff;
      oexp_in   = oexp_ff;
      none_in   = none_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         tdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_number <= tdf_pkg::NUM_W'(1)) begin
                  prime_in = '0;
                  oexp_in  = '0;
                  none_in  = 1'b1;
                  last_in  = 1'b1;
                  state_in = tdf_pkg::ST_OUT;
               end else begin
                  rem_in   = req_number;
                  cand_in  = tdf_pkg::FIRST_CAND;
                  sq_in    = tdf_pkg::FIRST_SQ;
                  exp_in   = '0;
                  state_in = tdf_pkg::ST_TEST;
               end
            end
         end
         tdf_pkg::ST_TEST: begin
            if (sq_ff > {{(tdf_pkg::SQ_W-tdf_pkg::NUM_W){1'b0}}, rem_ff}) begin
               prime_in = rem_ff;
               oexp_in  = tdf_pkg::EXP_W'(1);
               none_in  = 1'b0;
               last_in  = 1'b1;
               state_in = tdf_pkg::ST_OUT;
            end else begin
               part_in  = '0;
               quo_in   = rem_ff;
               cnt_in   = '0;
               state_in = tdf_pkg::ST_DIV;
            end
         end
         tdf_pkg::ST_DIV: begin
            part_in = part_step;
            quo_in  = quo_step;
            cnt_in  = cnt_ff + tdf_pkg::CNT_W'(1);
            if (cnt_ff == tdf_pkg::CNT_W'(tdf_pkg::DIV_CYCLES - 1)) begin
               state_in = tdf_pkg::ST_EVAL;
            end
         end
         tdf_pkg::ST_EVAL: begin
            if (part_ff == '0) begin
               rem_in   = quo_ff;
               exp_in   = exp_ff + tdf_pkg::EXP_W'(1);
               part_in  = '0;
               cnt_in   = '0;
               state_in = tdf_pkg::ST_DIV;
            end else begin
               cand_in = cand_adv;
               sq_in   = sq_adv;
               exp_in  = '0;
               if (exp_ff != '0) begin
                  prime_in = {{(tdf_pkg::NUM_W-tdf_pkg::CAND_W){1'b0}}, cand_ff};
                  oexp_in  = exp_ff;
                  none_in  = 1'b0;
                  last_in  = (rem_ff == tdf_pkg::NUM_W'(1));
                  state_in = tdf_pkg::ST_OUT;
               end else begin
                  state_in = tdf_pkg::ST_TEST;
               end
            end
         end
         tdf_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = last_ff ? tdf_pkg::ST_IDLE : tdf_pkg::ST_TEST;
            end
         end
         default: begin
            state_in = tdf_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_prime_factor = prime_ff;
   assign rsp_exponent     = oexp_ff;
   assign rsp_no_factors   = none_ff;
   assign rsp_last_factor  = last_ff;

endmodule

// ===== test/trial_division_factorizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer_tb: self-checking bench for the factorizer
// Builds its own prime table, predicts the (prime, exponent) run of every
// accepted number and checks each result item in order. Covers the trivial
// inputs, field extremes, output backpressure with a long stall, and random
// mostly smooth numbers under random gaps on both channels.
// ----------------------------------------------------------------------------
module trial_division_factorizer_tb;

   localparam int unsigned PRIME_LIMIT     = 65536;
   localparam int unsigned TABLE_DEPTH     = 6542;
   localparam int unsigned MAX_FACTORS     = 9;
   localparam int unsigned SMALL_PRIMES    = 54;
   localparam int unsigned RANDOM_ITEMS    = 80;
   localparam int unsigned HOLD_OFF_CYCLES = 3000;
   localparam int unsigned DRAIN_CYCLES    = 50;
   localparam int unsigned MAX_REPORTS     = 40;
   localparam longint     CYCLE_LIMIT     = 4000000;

   typedef struct {
      logic [tdf_pkg::NUM_W-1:0] number;
      logic [tdf_pkg::NUM_W-1:0] prime;
      logic [tdf_pkg::EXP_W-1:0] exponent;
      logic                      no_factors;
      logic                      last_factor;
   } factor_item_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [tdf_pkg::NUM_W-1:0] req_number;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [tdf_pkg::NUM_W-1:0] rsp_prime_factor;
   logic [tdf_pkg::EXP_W-1:0] rsp_exponent;
   logic                      rsp_no_factors;
   logic                      rsp_last_factor;

   logic [15:0]     prime_list [TABLE_DEPTH];
   int unsigned     prime_count;
   factor_item_type expected_factors [$];
   factor_item_type head_factor;
   int unsigned     mismatch_count;
   longint          cycle_count;
   int unsigned     stall_left;
   bit              calm;
   bit              hold_request;

   trial_division_factorizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prime_factor (rsp_prime_factor),
      .rsp_exponent     (rsp_exponent),
      .rsp_no_factors   (rsp_no_factors),
      .rsp_last_factor  (rsp_last_factor)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   task automatic build_prime_table();
      bit          composite [PRIME_LIMIT];
      int unsigned i;
      int unsigned j;
      prime_count = 0;
      for (i = 2; i < PRIME_LIMIT; i++) begin
         if (!composite[i]) begin
            if (prime_count < TABLE_DEPTH) begin
               prime_list[prime_count] = 16'(i);
               prime_count++;
            end
            for (j = i * i; j < PRIME_LIMIT; j += i)
               composite[j] = 1'b1;
         end
      end
   endtask

   task automatic factorize_number(input logic [tdf_pkg::NUM_W-1:0] number);
      factor_item_type           run [MAX_FACTORS];
      logic [tdf_pkg::NUM_W-1:0] remainder;
      logic [tdf_pkg::NUM_W-1:0] p;
      int unsigned               found;
      int unsigned               multiplicity;
      int unsigned               i;
      remainder = number;
      found = 0;
      if (number <= 1) begin
         run[0] = '{number, '0, '0, 1'b1, 1'b1};
         found = 1;
      end else begin
         for (i = 0; i < prime_count && found < MAX_FACTORS; i++) begin
            p = tdf_pkg::NUM_W'(prime_list[i]);
            if (p < 2) break;
            if (64'(p) * 64'(p) > 64'(number)) break;
            multiplicity = 0;
            while (remainder % p == 0) begin
               remainder = remainder / p;
               multiplicity++;
            end
            if (multiplicity != 0) begin
               run[found] = '{number, p, tdf_pkg::EXP_W'(multiplicity), 1'b0, 1'b0};
               found++;
            end
         end
         if (remainder > 1 && found < MAX_FACTORS) begin
            run[found] = '{number, remainder, tdf_pkg::EXP_W'(1), 1'b0, 1'b0};
            found++;
         end
         run[found-1].last_factor = 1'b1;
      end
      for (i = 0; i < found; i++)
         expected_factors.insert(expected_factors.size(), run[i]);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // mostly smooth numbers
   function automatic logic [tdf_pkg::NUM_W-1:0] random_number();
      logic [63:0] value;
      logic [63:0] p;
      int unsigned kind;
      int unsigned picks;
      int unsigned i;
      kind = $urandom_range(0, 19);
      if (kind == 0) return tdf_pkg::NUM_W'($urandom_range(0, 1));
      if (kind < 5) return tdf_pkg::NUM_W'($urandom_range(2, 1 << 18));
      value = (kind < 10) ? 64'($urandom_range(2, 1 << 17)) : 64'd1;
      picks = (kind >= 15) ? 40 : $urandom_range(1, 12);
      for (i = 0; i < picks; i++) begin
         p = 64'(prime_list[$urandom_range(0, SMALL_PRIMES - 1)]);
         if (value * p <= 64'hFFFF_FFFF) value = value * p;
      end
      return value[tdf_pkg::NUM_W-1:0];
   endfunction

   task automatic report_mismatch(input string field,
                                  input logic [tdf_pkg::NUM_W-1:0] want,
                                  input logic [tdf_pkg::NUM_W-1:0] got,
                                  input logic [tdf_pkg::NUM_W-1:0] number);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %s for number %0d: expected %0d, got %0d",
                  field, number, want, got);
   endtask

   task automatic send_number(input logic [tdf_pkg::NUM_W-1:0] number);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= number;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      factorize_number(number);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_factors.size() != 0) @(posedge clock);
   endtask

   task automatic test_trivial_inputs();
      send_number('0);
      send_number(tdf_pkg::NUM_W'(1));
      send_number('0);
      pause_until_drained();
   endtask

   task automatic test_extreme_numbers();
      logic [tdf_pkg::NUM_W-1:0] corner [12];
      int unsigned               i;
      corner = '{32'd2, 32'd3, 32'd4, 32'd63001, 32'd65537, 32'hFFFF_0000,
                 32'd4294836225, 32'h8000_0000, 32'hFFFF_FFFF, 32'd223092870,
                 32'd4238764530, 32'hFFFF_FFFB};
      for (i = 0; i < 12; i++)
         send_number(corner[i]);
      pause_until_drained();
   endtask

   task automatic test_output_backpressure();
      hold_request = 1'b1;
      calm = 1'b1;
      repeat (4) send_number(random_number());
      calm = 1'b0;
      pause_until_drained();
   endtask

   task automatic test_random_factorizations();
      int unsigned i;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 40 && i < 60);
         send_number(random_number());
      end
      calm = 1'b0;
      pause_until_drained();
   endtask

   initial begin
      rsp_ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_factors.size() == 0) begin
            report_mismatch("unexpected item", '0, rsp_prime_factor, '0);
         end else begin
            head_factor = expected_factors.pop_front();
            if (rsp_prime_factor !== head_factor.prime)
               report_mismatch("prime_factor", head_factor.prime, rsp_prime_factor,
                               head_factor.number);
            if (rsp_exponent !== head_factor.exponent)
               report_mismatch("exponent", tdf_pkg::NUM_W'(head_factor.exponent),
                               tdf_pkg::NUM_W'(rsp_exponent), head_factor.number);
            if (rsp_no_factors !== head_factor.no_factors)
               report_mismatch("no_factors", tdf_pkg::NUM_W'(head_factor.no_factors),
                               tdf_pkg::NUM_W'(rsp_no_factors), head_factor.number);
            if (rsp_last_factor !== head_factor.last_factor)
               report_mismatch("last_factor", tdf_pkg::NUM_W'(head_factor.last_factor),
                               tdf_pkg::NUM_W'(rsp_last_factor), head_factor.number);
         end
      end
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_number     = '0;
      mismatch_count = 0;
      calm           = 1'b0;
      hold_request   = 1'b0;
      build_prime_table();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_trivial_inputs();
      test_extreme_numbers();
      test_output_backpressure();
      test_random_factorizations();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_factors.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
